@@ src/mco_pkg.sv @@
// Shared types and constants for the midpoint circle outline generator.
package mco_pkg;

	localparam int COORD_W = 12;
	localparam int OFS_W = 8;
	localparam int DEC_W = 11;
	localparam int COLOR_W = 16;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 40;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [2:0] LAST_PIXEL = 3'd7;

	typedef struct packed {
		logic [OFS_W-1:0]   x;
		logic [OFS_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               fin;
	} mco_snap_t;

endpackage

@@ src/midpoint_circle_outline.sv @@
// Midpoint circle outline generator, centered on the display.
// Each input is held in the input register until the pixel emitter is free to load it.
// Output: eight pixels per drawing item, one pixel per cycle while m_tready is high;
//   an item that draws nothing sends no pixels.
//   The next item is accepted as the last pixel leaves.
// Reset: arst_n clears the circle state, the input valid flag and the emitter's busy flag and index.
module midpoint_circle_outline #(
	parameter int DISPLAY_WIDTH = 240,
	parameter int DISPLAY_HEIGHT = 240,
	parameter int MAX_RADIUS = 255
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mco_pkg::IN_DATA_W-1:0]  s_tdata,   // ref_radius, scale, color
	input  logic                           s_tuser,   // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mco_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, pixel_color
	output logic                           m_tlast,
	output logic                           m_tuser    // finished
);
	import mco_pkg::*;

	logic                v_s1;
	logic                op_s1;
	logic [15:0]         ref_s1;
	logic [15:0]         scl_s1;
	logic [COLOR_W-1:0]  col_s1;

	logic                active_q;
	logic [OFS_W-1:0]    x_q;
	logic [OFS_W-1:0]    y_q;
	logic [DEC_W-1:0]    dec_q;
	logic [COLOR_W-1:0]  color_q;

	logic                emit_free;
	logic                adv;
	logic                load;
	mco_snap_t           snap;

	logic [31:0]         prod;
	logic [32:0]         rnd_sum;
	logic [16:0]         rnd;
	logic [OFS_W-1:0]    radius;
	logic [OFS_W-1:0]    nx;
	logic [OFS_W-1:0]    ny;
	logic [OFS_W:0]      diff;
	logic [DEC_W-1:0]    inc;
	logic [DEC_W-1:0]    ndec;
	logic                fin;

	assign adv = v_s1 && emit_free;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser;
			ref_s1 <= s_tdata[15:0];
			scl_s1 <= s_tdata[31:16];
			col_s1 <= s_tdata[47:32];
		end
	end

	always_comb begin
		prod = 32'(ref_s1) * 32'(scl_s1);
		rnd_sum = {1'b0, prod} + 33'h0_0000_8000;
		rnd = rnd_sum[32:16];
		radius = (rnd > 17'(MAX_RADIUS)) ? OFS_W'(MAX_RADIUS) : rnd[OFS_W-1:0];

		nx = x_q + 8'd1;
		ny = dec_q[DEC_W-1] ? y_q : (y_q - 8'd1);
		diff = {1'b0, nx} - {1'b0, ny};
		if (dec_q[DEC_W-1]) begin
			inc = {2'b00, nx, 1'b1};
		end else begin
			inc = {diff[OFS_W], diff, 1'b1};
		end
		ndec = dec_q + inc;
		fin = !(nx < ny);

		load = 1'b0;
		snap = '{x: nx, y: ny, color: color_q, fin: fin};
		if (adv) begin
			case (op_s1)
				OP_START: begin
					load = (radius != '0);
					snap = '{x: '0, y: radius, color: col_s1, fin: 1'b0};
				end
				OP_STEP: begin
					load = active_q;
				end
				default: begin
					load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			dec_q <= '0;
			color_q <= '0;
		end else if (adv) begin
			if (op_s1 == OP_START) begin
				color_q <= col_s1;
				active_q <= (radius != '0);
				if (radius != '0) begin
					x_q <= '0;
					y_q <= radius;
					dec_q <= DEC_W'(1) - {{(DEC_W-OFS_W){1'b0}}, radius};
				end
			end else if (active_q) begin
				x_q <= nx;
				y_q <= ny;
				dec_q <= ndec;
				if (fin) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	mco_emit #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.snap(snap),
		.free(emit_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

@@ src/mco_emit.sv @@
// Octant emitter: holds one step's offsets and streams its eight mirrored pixels.
module mco_emit #(
	parameter int DISPLAY_WIDTH = 240,
	parameter int DISPLAY_HEIGHT = 240
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  mco_pkg::mco_snap_t            snap,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mco_pkg::OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, pixel_color
	output logic                          m_tlast,
	output logic                          m_tuser    // finished
);
	import mco_pkg::*;

	localparam logic [COORD_W-1:0] CX = COORD_W'(DISPLAY_WIDTH / 2);
	localparam logic [COORD_W-1:0] CY = COORD_W'(DISPLAY_HEIGHT / 2);

	mco_snap_t   snap_q;
	logic [2:0]  idx_q;
	logic        busy_q;
	logic        done;
	logic [COORD_W-1:0] col_ofs;
	logic [COORD_W-1:0] row_ofs;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;

	assign done = busy_q && m_tready && (idx_q == LAST_PIXEL);
	assign free = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (busy_q && m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q <= snap;
		end
	end

	// idx[2] swaps x/y, idx[0] negates the column, idx[1] negates the row
	always_comb begin
		col_ofs = {{(COORD_W-OFS_W){1'b0}}, idx_q[2] ? snap_q.y : snap_q.x};
		row_ofs = {{(COORD_W-OFS_W){1'b0}}, idx_q[2] ? snap_q.x : snap_q.y};
		px = idx_q[0] ? (CX - col_ofs) : (CX + col_ofs);
		py = idx_q[1] ? (CY - row_ofs) : (CY + row_ofs);
	end

	assign m_tvalid = busy_q;
	assign m_tdata = {snap_q.color, py, px};
	assign m_tlast = (idx_q == LAST_PIXEL);
	assign m_tuser = snap_q.fin;

endmodule

@@ dv/midpoint_circle_outline_tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for midpoint_circle_outline with a scoreboard.
module midpoint_circle_outline_tb;
	import mco_pkg::*;

	localparam int DISP_W = 240;
	localparam int DISP_H = 240;
	localparam int MAX_RAD = 255;
	localparam int CENTER_X = DISP_W / 2;
	localparam int CENTER_Y = DISP_H / 2;
	localparam int RANDOM_ITEMS = 150;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               fin;
	} pixel_t;

	class pixel_scoreboard;
		bit busy;
		int off_x;
		int off_y;
		int decision;
		logic [COLOR_W-1:0] held_color;
		pixel_t expected_pixels[$];
		int errors;
		int checked;
		int circles_done;

		function new();
			busy = 0;
			off_x = 0;
			off_y = 0;
			decision = 0;
			held_color = '0;
			errors = 0;
			checked = 0;
			circles_done = 0;
		endfunction

		task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
			errors++;
			$display("%t mismatch on %s: got %h, expected %h (pixel %0d)",
				$realtime, field, got, want, checked);
		endtask

		function void queue_octants(bit fin);
			int xs[8];
			int ys[8];
			pixel_t p;
			xs = '{CENTER_X + off_x, CENTER_X - off_x, CENTER_X + off_x, CENTER_X - off_x,
				CENTER_X + off_y, CENTER_X - off_y, CENTER_X + off_y, CENTER_X - off_y};
			ys = '{CENTER_Y + off_y, CENTER_Y + off_y, CENTER_Y - off_y, CENTER_Y - off_y,
				CENTER_Y + off_x, CENTER_Y + off_x, CENTER_Y - off_x, CENTER_Y - off_x};
			for (int k = 0; k < 8; k++) begin
				p.x = COORD_W'(xs[k]);
				p.y = COORD_W'(ys[k]);
				p.color = held_color;
				p.last = (k == 7);
				p.fin = fin;
				expected_pixels.push_back(p);
			end
		endfunction

		// Called once per accepted input transaction.
		function void note_item(logic op, logic [15:0] rad_ref, logic [15:0] rad_scale,
			logic [15:0] col);
			logic [32:0] prod;
			int rad;
			if (op == OP_START) begin
				prod = 33'(rad_ref) * 33'(rad_scale) + 33'h8000;
				rad = int'(prod >> 16);
				if (rad > MAX_RAD)
					rad = MAX_RAD;
				held_color = col;
				if (rad == 0) begin
					busy = 0;
					return;
				end
				busy = 1;
				off_x = 0;
				off_y = rad;
				decision = 1 - rad;
				queue_octants(0);
			end else if (busy) begin
				off_x++;
				if (decision < 0) begin
					decision += 2 * off_x + 1;
				end else begin
					off_y--;
					decision += 2 * (off_x - off_y) + 1;
				end
				if (off_x >= off_y) begin
					busy = 0;
					circles_done++;
					queue_octants(1);
				end else begin
					queue_octants(0);
				end
			end
		endfunction

		task check_pixel(logic [OUT_DATA_W-1:0] data, logic last, logic fin);
			pixel_t want;
			checked++;
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected pixel (x)", 16'(data[11:0]), 16'h0);
				return;
			end
			want = expected_pixels.pop_front();
			if (data[11:0] !== want.x)
				report_mismatch("pixel_x", 16'(data[11:0]), 16'(want.x));
			if (data[23:12] !== want.y)
				report_mismatch("pixel_y", 16'(data[23:12]), 16'(want.y));
			if (data[39:24] !== want.color)
				report_mismatch("pixel_color", data[39:24], want.color);
			if (last !== want.last)
				report_mismatch("last_of_step", 16'(last), 16'(want.last));
			if (fin !== want.fin)
				report_mismatch("finished", 16'(fin), 16'(want.fin));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // ref_radius, scale, color
	logic s_tuser;                   // operation
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // pixel_x, pixel_y, pixel_color
	logic m_tlast;
	logic m_tuser;                   // finished

	pixel_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	int counted_items = 0;
	int n_starts = 0;
	int n_steps = 0;
	int n_ignored = 0;
	int hold_left = 0;
	bit held_once = 0;

	midpoint_circle_outline #(
		.DISPLAY_WIDTH(DISP_W),
		.DISPLAY_HEIGHT(DISP_H),
		.MAX_RADIUS(MAX_RAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycles,
				sb.expected_pixels.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Drive one input transaction and wait for it to be taken.
	task automatic push(logic op, logic [15:0] rad_ref, logic [15:0] rad_scale,
		logic [15:0] col);
		bit gaps;
		gaps = !(items_sent >= 40 && items_sent < 80);
		while (gaps && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {col, rad_scale, rad_ref};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (op == OP_START) begin
			n_starts++;
			counted_items++;
		end else if (sb.busy) begin
			n_steps++;
			counted_items++;
		end else begin
			n_ignored++;
		end
		sb.note_item(op, rad_ref, rad_scale, col);
	endtask

	task automatic step_rand();
		push(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic directed_items();
		step_rand();                                   // step on an idle generator
		push(OP_START, 16'h0000, 16'hFFFF, 16'hFFFF);  // zero radius
		push(OP_START, 16'hFFFF, 16'h0000, 16'h1234);  // zero radius
		push(OP_START, 16'h0001, 16'h7FFF, 16'h4321);  // rounds down to zero
		push(OP_START, 16'h0080, 16'h0100, 16'h0000);  // rounds up to one
		step_rand();                                   // radius one finishes at once
		step_rand();                                   // idle after finish
		push(OP_START, 16'hFFFF, 16'hFFFF, 16'hA5A5);  // saturates
		repeat (3) step_rand();
		push(OP_START, 16'h0300, 16'h0100, 16'h5A5A);  // restart while active
		while (sb.busy) step_rand();
		push(OP_START, 16'h0A00, 16'h0180, 16'hFFFF);
		repeat (3) step_rand();
		push(OP_START, 16'h0000, 16'h0000, 16'h0F0F);  // zero radius clears a live circle
		step_rand();
		push(OP_START, 16'h0100, 16'h0800, 16'hF00F);
		while (sb.busy) step_rand();
	endtask

	task automatic random_items();
		int pick;
		int target;
		int base;
		int other;
		int abandon;
		int steps;
		while (counted_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				step_rand();
			end else if (pick < 20) begin
				push(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
				repeat ($urandom_range(0, 6)) step_rand();
			end else begin
				target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70)
					: $urandom_range(1, 20);
				base = $urandom_range(256, 65535);
				other = (target << 16) / base;
				if ($urandom_range(0, 1))
					push(OP_START, 16'(base), 16'(other), 16'($urandom));
				else
					push(OP_START, 16'(other), 16'(base), 16'($urandom));
				abandon = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 8) : -1;
				steps = 0;
				while (sb.busy && steps != abandon) begin
					step_rand();
					steps++;
				end
			end
		end
	endtask

	// Pixel sink: random stalls, one quiet stretch, one long hold-off.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_pixel(m_tdata, m_tlast, m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held_once && sb.checked >= 240) begin
				held_once = 1;
				hold_left = 300;
				m_tready <= 1'b0;
			end else if (sb.checked >= 600 && sb.checked < 1000) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 7);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_START;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		directed_items();
		random_items();
		s_tvalid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("Run covered %0d starts, %0d steps and %0d steps on an idle generator;",
			n_starts, n_steps, n_ignored);
		$display("%0d circles completed, %0d pixels checked, %0d mismatches.",
			sb.circles_done, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
